### rtl/core/lcd_pkg.sv
// ============================================================================
// lcd_pkg: shared types and constants for the LRU cache directory.
// Holds the configuration width, request action codes, the controller state
// type and the command bundle between controller and datapath.
// ============================================================================
package lcd_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } lcd_state_t;

  typedef struct packed {
    logic load_req;
    logic execute;
  } lcd_cmd_t;

endpackage

### rtl/core/lcd_ifs.sv
// ============================================================================
// lcd_ifs: request and response channels of the LRU cache directory.
// Each channel carries valid, ready and one word of payload.
// ============================================================================
interface lcd_req_if #(
  parameter int KEY_BITS = 32
);
  logic                valid;
  logic                ready;
  logic                action;
  logic [KEY_BITS-1:0] object_key;

  modport source (output valid, output action, output object_key, input ready);
  modport sink   (input valid, input action, input object_key, output ready);
endinterface

interface lcd_rsp_if #(
  parameter int KEY_BITS = 32,
  parameter int OCC_W    = 5
);
  logic                valid;
  logic                ready;
  logic                hit;
  logic                found_removed;
  logic                evict_valid;
  logic [KEY_BITS-1:0] evicted_key;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output hit, output found_removed, output evict_valid,
                  output evicted_key, output occupancy, input ready);
  modport sink   (input valid, input hit, input found_removed, input evict_valid,
                  input evicted_key, input occupancy, output ready);
endinterface

### rtl/core/lcd_ctrl.sv
// ============================================================================
// lcd_ctrl: request sequencer.
// Takes a request word, then runs one update once the output register is free.
// ============================================================================
module lcd_ctrl
  import lcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lcd_cmd_t cmd
);

  lcd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The update writes the output register, so it waits for a free slot.
        if (!out_valid_r || out_ready) begin
          cmd.execute   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/core/lcd_datapath.sv
// ============================================================================
// lcd_datapath: entry store, recency ranks and result register.
// Performs the lookup, LRU selection and rank update of one request.
// ============================================================================
module lcd_datapath
  import lcd_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32,
  parameter int OCC_W    = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcd_cmd_t            cmd,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                req_action,
  input  logic [KEY_BITS-1:0] req_key,
  output logic                rsp_hit,
  output logic                rsp_found_removed,
  output logic                rsp_evict_valid,
  output logic [KEY_BITS-1:0] rsp_evicted_key,
  output logic [OCC_W-1:0]    rsp_occupancy
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [CW-1:0] ENTRIES_CW = CW'(ENTRIES);

  logic [CFG_W-1:0]    cap_r;
  logic                act_r;
  logic [KEY_BITS-1:0] key_r;

  logic [KEY_BITS-1:0] ekey_r   [ENTRIES];
  logic [IW-1:0]       rank_r   [ENTRIES];
  logic [IW-1:0]       rank_nxt [ENTRIES];
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [OCC_W-1:0]    count_r, count_nxt;

  logic                hit_r, found_r, ev_r;
  logic [KEY_BITS-1:0] evkey_r;

  logic [ENTRIES-1:0]  match, lru, valid_ev;
  logic                any_match, do_evict, have_free;
  logic [IW-1:0]       s_idx, free_idx, rank_s, cnt_m1;
  logic [CW-1:0]       eff_cap;
  logic [KEY_BITS-1:0] evkey;

  always_comb begin
    // Saturate the configured capacity into 1 .. ENTRIES.
    eff_cap = CW'(cap_r);
    if (eff_cap == '0) eff_cap = CW'(1);
    if (eff_cap > ENTRIES_CW) eff_cap = ENTRIES_CW;
    cnt_m1 = IW'(count_r - OCC_W'(1));

    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (ekey_r[i] == key_r);
      // Ranks are dense, so the least recent entry holds rank count - 1.
      lru[i]   = valid_r[i] && (rank_r[i] == cnt_m1);
    end
    any_match = |match;
    s_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) s_idx = IW'(i);
    end
    rank_s = rank_r[s_idx];

    do_evict = (act_r == ACT_ACCESS) && !any_match && (count_r != '0) &&
               (CW'(count_r) >= eff_cap);
    valid_ev = do_evict ? (valid_r & ~lru) : valid_r;
    evkey = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_evict && lru[i]) evkey = evkey | ekey_r[i];
    end

    have_free = 1'b0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_ev[i]) begin
        have_free = 1'b1;
        free_idx  = IW'(i);
      end
    end

    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) rank_nxt[i] = rank_r[i];

    if (act_r == ACT_REMOVE) begin
      if (any_match) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && rank_r[i] > rank_s) rank_nxt[i] = rank_r[i] - IW'(1);
        end
        valid_nxt[s_idx] = 1'b0;
        rank_nxt[s_idx]  = '0;
        count_nxt        = count_r - OCC_W'(1);
      end
    end else if (any_match) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_r[i] && rank_r[i] < rank_s) rank_nxt[i] = rank_r[i] + IW'(1);
      end
      rank_nxt[s_idx] = '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (do_evict && lru[i]) rank_nxt[i] = '0;
      end
      valid_nxt = valid_ev;
      if (do_evict) count_nxt = count_r - OCC_W'(1);
      if (have_free) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_ev[i]) rank_nxt[i] = rank_r[i] + IW'(1);
        end
        valid_nxt[free_idx] = 1'b1;
        rank_nxt[free_idx]  = '0;
        count_nxt           = count_nxt + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.execute) begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
        for (int i = 0; i < ENTRIES; i++) rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r <= req_action;
      key_r <= req_key;
    end
    if (cmd.execute) begin
      if ((act_r == ACT_ACCESS) && !any_match && have_free) ekey_r[free_idx] <= key_r;
      hit_r   <= (act_r == ACT_ACCESS) && any_match;
      found_r <= (act_r == ACT_REMOVE) && any_match;
      ev_r    <= do_evict;
      evkey_r <= evkey;
    end
  end

  assign rsp_hit           = hit_r;
  assign rsp_found_removed = found_r;
  assign rsp_evict_valid   = ev_r;
  assign rsp_evicted_key   = evkey_r;
  assign rsp_occupancy     = count_r;

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == OCC_W'($countones(valid_r)))
    else $error("entry count differs from number of valid entries");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= ENTRIES_CW)
    else $error("entry count above directory size");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && do_evict |=> !rsp_hit && !rsp_found_removed && (count_r == $past(count_r)))
    else $error("eviction changed occupancy or coincided with a hit");

endmodule

### rtl/core/lru_cache_directory.sv
// ============================================================================
// lru_cache_directory: fully associative cache directory with LRU replacement.
// Top level joining the request sequencer and the entry datapath.
// ============================================================================
// Usage: a request word (action, object_key) enters on in_req. An access
// reports a hit and makes the entry most recent; a miss inserts the key as
// most recent, first evicting the least recent key when occupancy has reached
// the configured capacity. A remove deletes the key and reports whether it
// was found. Every response word carries the occupancy after the request.
// The accept edge latches the word into the request register; the update
// then runs the parallel key compare and rank update over all entries into
// the output register as soon as that register is free, and in_req is held
// off until that update has run. The output register lets the
// next request be accepted while a response waits; if out_rsp stays stalled,
// the update of that next request waits, and in_req is held off after it.
// cfg_we writes the capacity register (reset 16, zero reads as one, values
// above ENTRIES saturate); write it only while the block is idle. Reset
// empties the directory and sets the capacity to its default.
module lru_cache_directory
  import lcd_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  lcd_req_if.sink          in_req,
  lcd_rsp_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int OCC_W = $clog2(ENTRIES + 1);

  lcd_cmd_t cmd;

  lcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  lcd_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .OCC_W    (OCC_W)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .req_action        (in_req.action),
    .req_key           (in_req.object_key),
    .rsp_hit           (out_rsp.hit),
    .rsp_found_removed (out_rsp.found_removed),
    .rsp_evict_valid   (out_rsp.evict_valid),
    .rsp_evicted_key   (out_rsp.evicted_key),
    .rsp_occupancy     (out_rsp.occupancy)
  );

endmodule
